// ===== design/cwfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cwfe_pkg
// Shared types and constants of the CAN window feature extractor.
// ----------------------------------------------------------------------------
package cwfe_pkg;

  localparam int ID_BITS        = 11;
  localparam int ID_TABLE_DEPTH = 2048;
  localparam int CFG_BITS       = 20;
  localparam int OUT_W          = 112;

  localparam logic [1:0] REG_FILL = 2'd0;
  localparam logic [1:0] REG_LOW  = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;

  localparam logic [19:0] FILL_RESET = 20'd10222;
  localparam logic [19:0] LOW_RESET  = 20'd4118;
  localparam logic [19:0] HIGH_RESET = 20'd778155;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [9:0]  MS_PER_US = 10'd1000;
  localparam logic [15:0] NORM_ONE  = 16'hFFFF;

  // Q16 log2 of a constant, evaluated at elaboration
  function automatic logic [21:0] log2_q16_of(input logic [63:0] v);
    int          e;
    logic [63:0] m;
    logic [15:0] frac;
    e    = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) e = i;
    end
    if (e > 30) m = v >> (e - 30);
    else        m = v << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {e[5:0], frac};
  endfunction

  localparam logic [21:0] LOG2_BASE = log2_q16_of(64'd1000);

  typedef struct packed {
    logic               upd;
    logic               clr;
    logic               ins;
    logic [ID_BITS-1:0] id;
  } cell_ctrl_t;

  typedef struct packed {
    logic start;
    logic ack;
  } intv_ctrl_t;

endpackage

// ===== design/cwfe_cell.sv =====
// ----------------------------------------------------------------------------
// cwfe_cell
// One slot of the window ID chain: holds an ID and its repeat count.
// ----------------------------------------------------------------------------
module cwfe_cell #(
  parameter int CW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cwfe_pkg::cell_ctrl_t         ctrl,
  input  logic                         nb_valid,
  input  logic [cwfe_pkg::ID_BITS-1:0] nb_id,
  input  logic [CW-1:0]                nb_cnt,
  output logic                         valid,
  output logic [cwfe_pkg::ID_BITS-1:0] id,
  output logic [CW-1:0]                cnt,
  output logic                         match
);

  logic                         valid_r;
  logic [cwfe_pkg::ID_BITS-1:0] id_r;
  logic [CW-1:0]                cnt_r;

  assign match = valid_r && (id_r == ctrl.id);
  assign valid = valid_r;
  assign id    = id_r;
  assign cnt   = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.upd) begin
      if (ctrl.clr)      valid_r <= 1'b0;
      else if (ctrl.ins) valid_r <= nb_valid;
    end
  end

  // shift from the neighbor on insert, bump the count on a hit
  always_ff @(posedge clk) begin
    if (ctrl.upd && !ctrl.clr) begin
      if (ctrl.ins) begin
        id_r  <= nb_id;
        cnt_r <= nb_cnt;
      end else if (match) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

endmodule

// ===== design/cwfe_interval.sv =====
// ----------------------------------------------------------------------------
// cwfe_interval
// Sequential ln(1+ms) and normalization of one interval to Q0.16.
// ----------------------------------------------------------------------------
module cwfe_interval #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cwfe_pkg::intv_ctrl_t ctrl,
  input  logic [TIME_BITS-1:0] delta,
  input  logic [19:0]          low,
  input  logic [19:0]          high,
  output logic                 done,
  output logic [15:0]          norm
);

  localparam int EW = $clog2(TIME_BITS);
  localparam int LW = EW + 16;
  localparam int PW = LW + 30;
  localparam logic [3:0] ITER_LAST = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SQ, S_SUB, S_MUL, S_CMP, S_DIV, S_DONE
  } state_t;

  state_t               state_r;
  logic [TIME_BITS-1:0] v_r;
  logic [EW-1:0]        e_r;
  logic [30:0]          m_r;
  logic [15:0]          frac_r;
  logic [3:0]           cnt_r;
  logic [LW-1:0]        d_r;
  logic [LW-1:0]        ln_r;
  logic [19:0]          rem_r;
  logic [15:0]          lo_r;
  logic [19:0]          den_r;
  logic [15:0]          q_r;
  logic [15:0]          norm_r;

  logic [61:0] sq;
  logic [31:0] sq_t;
  logic [LW-1:0] lval;
  logic [LW-1:0] lbase;
  logic [PW-1:0] prod;
  logic [LW-1:0] low_x;
  logic [LW-1:0] high_x;
  logic [19:0]   diff;
  logic [35:0]   num;
  logic [20:0]   rr;
  logic          ge;

  always_comb begin
    sq     = 62'(m_r) * 62'(m_r);
    sq_t   = sq[61:30];
    lval   = {e_r, frac_r};
    lbase  = LW'(cwfe_pkg::LOG2_BASE);
    prod   = PW'(d_r) * PW'(cwfe_pkg::LN2_Q30) + (PW'(1) << 29);
    low_x  = LW'(low);
    high_x = LW'(high);
    diff   = 20'(ln_r - low_x);
    num    = {diff, 16'b0} - {16'b0, diff};
    rr     = {rem_r, lo_r[15]};
    ge     = rr >= {1'b0, den_r};
  end

  assign done = (state_r == S_DONE);
  assign norm = norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (ctrl.start) begin
            v_r     <= delta + TIME_BITS'(cwfe_pkg::MS_PER_US);
            e_r     <= EW'(TIME_BITS - 1);
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // bring the leading one to the top, a byte or a bit at a time
          if (v_r[TIME_BITS-1]) begin
            m_r     <= v_r[TIME_BITS-1 -: 31];
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end else if (v_r[TIME_BITS-1 -: 8] == 8'd0) begin
            v_r <= v_r << 8;
            e_r <= e_r - EW'(8);
          end else begin
            v_r <= v_r << 1;
            e_r <= e_r - EW'(1);
          end
        end
        S_SQ: begin
          if (sq_t[31]) begin
            m_r    <= sq_t[31:1];
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            m_r    <= sq_t[30:0];
            frac_r <= {frac_r[14:0], 1'b0};
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == ITER_LAST) state_r <= S_SUB;
        end
        S_SUB: begin
          d_r     <= (lval > lbase) ? lval - lbase : '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          ln_r    <= prod[PW-1:30];
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (ln_r <= low_x) begin
            norm_r  <= '0;
            state_r <= S_DONE;
          end else if (high <= low || ln_r >= high_x) begin
            norm_r  <= cwfe_pkg::NORM_ONE;
            state_r <= S_DONE;
          end else begin
            rem_r   <= num[35:16];
            lo_r    <= num[15:0];
            den_r   <= high - low;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= ge ? 20'(rr - {1'b0, den_r}) : rr[19:0];
          lo_r  <= lo_r << 1;
          q_r   <= {q_r[14:0], ge};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == ITER_LAST) begin
            norm_r  <= {q_r[14:0], ge};
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctrl.ack) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/can_window_feature_extract.sv =====
// ----------------------------------------------------------------------------
// can_window_feature_extract
// Per-frame CAN feature row with interval since last sighting of the ID.
// ----------------------------------------------------------------------------
// One CAN frame per input item on in_*, one feature row per frame on out_*.
// Registers fill_interval_us, log_low_q16, log_high_q16 sit on the cfg_ APB
// port at 0x0, 0x4, 0x8; write them only while the block is idle.
// Each item is handled alone: the last-seen table is read at the accepting
// edge, the look-up state writes it back and updates the window chain, then
// the interval unit runs: normalize, squaring, ln and compare, division when
// the value falls between the bounds, and the hand-over of the result. The
// next item can be taken in the cycle after the row loads.
// The window tracker is a chain of WINDOW_FRAMES cells; a new ID enters at
// the head and pushes the others down; the last frame of a window clears it.
// After reset the last-seen table is cleared one entry a cycle, all 2048 entries,
// with in_tready low. A finished row waits in the output register while the
// receiver stalls; the next item is taken meanwhile and holds before its
// own result until the register frees up.
// ----------------------------------------------------------------------------
module can_window_feature_extract #(
  parameter int WINDOW_FRAMES = 32,
  parameter int TIME_BITS     = 48
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // can_id, data_length, byte_0..byte_7, timestamp_us
  input  logic [((79+TIME_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // frame_id, frame_length, payload_word, interval_norm, slot_index,
  // distinct_ids, repeat_peak
  output logic [cwfe_pkg::OUT_W-1:0]            out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [3:0]                            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int CW = $clog2(WINDOW_FRAMES + 1);
  localparam int SW = $clog2(WINDOW_FRAMES);
  localparam int AW = $clog2(cwfe_pkg::ID_TABLE_DEPTH);
  localparam int ME = TIME_BITS + 1;
  localparam int TS_LO = 79;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_WAIT} state_t;

  // configuration
  logic [19:0] fill_r, low_r, high_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= cwfe_pkg::FILL_RESET;
      low_r  <= cwfe_pkg::LOW_RESET;
      high_r <= cwfe_pkg::HIGH_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cwfe_pkg::REG_FILL: fill_r <= cfg_pwdata[19:0];
        cwfe_pkg::REG_LOW:  low_r  <= cfg_pwdata[19:0];
        cwfe_pkg::REG_HIGH: high_r <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cwfe_pkg::REG_FILL: cfg_prdata = {12'b0, fill_r};
      cwfe_pkg::REG_LOW:  cfg_prdata = {12'b0, low_r};
      cwfe_pkg::REG_HIGH: cfg_prdata = {12'b0, high_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // control
  state_t                       state_r;
  logic                         clear_r;
  logic [AW-1:0]                clr_cnt_r;
  logic                         in_acc;
  logic [cwfe_pkg::ID_BITS-1:0] id_r;
  logic [3:0]                   dlc_r;
  logic [63:0]                  payload_r;
  logic [TIME_BITS-1:0]         ts_r;

  assign in_tready = (state_r == ST_IDLE) && !clear_r;
  assign in_acc    = in_tvalid && in_tready;

  // last-seen table: {seen, time}
  logic [ME-1:0]  seen_mem [cwfe_pkg::ID_TABLE_DEPTH];
  logic [ME-1:0]  rd_q;
  logic [AW-1:0]  rd_addr;

  assign rd_addr = in_tdata[AW-1:0];

  always_ff @(posedge clk) begin
    rd_q <= seen_mem[rd_addr];
    if (clear_r)                   seen_mem[clr_cnt_r] <= '0;
    else if (state_r == ST_LOOK)   seen_mem[id_r[AW-1:0]] <= {1'b1, ts_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clear_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(cwfe_pkg::ID_TABLE_DEPTH - 1)) clear_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r      <= in_tdata[10:0];
      dlc_r     <= in_tdata[14:11];
      payload_r <= in_tdata[78:15];
      ts_r      <= in_tdata[TS_LO +: TIME_BITS];
    end
  end

  // interval since last sighting; negative difference counts as zero, an unseen ID takes fill_interval_us
  logic [TIME_BITS-1:0] diff_t;
  logic [TIME_BITS-1:0] delta;

  always_comb begin
    diff_t = ts_r - rd_q[TIME_BITS-1:0];
    if (rd_q[ME-1]) delta = diff_t[TIME_BITS-1] ? '0 : diff_t;
    else            delta = TIME_BITS'(fill_r);
  end

  // window chain
  cwfe_pkg::cell_ctrl_t         cctl;
  logic [WINDOW_FRAMES-1:0]     c_valid, c_match;
  logic [cwfe_pkg::ID_BITS-1:0] c_id  [WINDOW_FRAMES];
  logic [CW-1:0]                c_cnt [WINDOW_FRAMES];
  logic                         found;
  logic [CW-1:0]                hit_cnt;
  logic [CW-1:0]                new_cnt;
  logic [CW-1:0]                distinct_r, distinct_nxt;
  logic [CW-1:0]                max_r, max_nxt;
  logic [SW-1:0]                slot_r;
  logic                         last;

  always_comb begin
    hit_cnt = '0;
    for (int k = 0; k < WINDOW_FRAMES; k++) begin
      if (c_match[k]) hit_cnt = hit_cnt | c_cnt[k];
    end
    found        = |c_match;
    new_cnt      = found ? hit_cnt + CW'(1) : CW'(1);
    max_nxt      = (max_r > new_cnt) ? max_r : new_cnt;
    distinct_nxt = distinct_r + CW'(!found);
    last         = (slot_r == SW'(WINDOW_FRAMES - 1));
    cctl.upd     = (state_r == ST_LOOK);
    cctl.clr     = last;
    cctl.ins     = !found;
    cctl.id      = id_r;
  end

  for (genvar k = 0; k < WINDOW_FRAMES; k++) begin : g_cell
    if (k == 0) begin : g_head
      cwfe_cell #(.CW(CW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctrl(cctl),
        .nb_valid(1'b1), .nb_id(id_r), .nb_cnt(CW'(1)),
        .valid(c_valid[k]), .id(c_id[k]), .cnt(c_cnt[k]), .match(c_match[k])
      );
    end else begin : g_body
      cwfe_cell #(.CW(CW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctrl(cctl),
        .nb_valid(c_valid[k-1]), .nb_id(c_id[k-1]), .nb_cnt(c_cnt[k-1]),
        .valid(c_valid[k]), .id(c_id[k]), .cnt(c_cnt[k]), .match(c_match[k])
      );
    end
  end

  // interval unit
  cwfe_pkg::intv_ctrl_t ictl;
  logic                 i_done;
  logic [15:0]          i_norm;
  logic                 out_free;
  logic                 load;

  assign out_free   = !out_tvalid || out_tready;
  assign load       = (state_r == ST_WAIT) && i_done && out_free;
  assign ictl.start = (state_r == ST_LOOK);
  assign ictl.ack   = load;

  cwfe_interval #(.TIME_BITS(TIME_BITS)) u_intv (
    .clk(clk), .rst_n(rst_n), .ctrl(ictl), .delta(delta),
    .low(low_r), .high(high_r), .done(i_done), .norm(i_norm)
  );

  // window result held for the row
  logic [4:0] w_slot_r;
  logic       w_last_r;
  logic [5:0] w_dist_r, w_max_r;
  logic       out_valid_r;
  logic [cwfe_pkg::OUT_W-1:0] out_data_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      slot_r     <= '0;
      distinct_r <= '0;
      max_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: if (in_acc) state_r <= ST_LOOK;
        ST_LOOK: begin
          w_slot_r <= 5'(slot_r);
          w_last_r <= last;
          w_dist_r <= last ? 6'(distinct_nxt) : 6'd0;
          w_max_r  <= last ? 6'(max_nxt) : 6'd0;
          if (last) begin
            slot_r     <= '0;
            distinct_r <= '0;
            max_r      <= '0;
          end else begin
            slot_r     <= slot_r + SW'(1);
            distinct_r <= distinct_nxt;
            max_r      <= max_nxt;
          end
          state_r <= ST_WAIT;
        end
        ST_WAIT: if (load) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {w_max_r, w_dist_r, w_slot_r, i_norm, payload_r, dlc_r, id_r};
      out_last_r <= w_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !in_tready)
    else $error("item accepted during table clear");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_LOOK)
    else $error("accepted item not looked up");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[99:95] == 5'(WINDOW_FRAMES - 1))
    else $error("window closed at wrong slot");

  a_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[111:100] == 12'd0)
    else $error("window counts shown before window end");

endmodule
